### src/iaal_pkg.sv
// Shared types and constants for the indexed array list.
package iaal_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int OUT_CNT_W    = 8;
  // Wide enough for any capacity up to 4096 plus one.
  localparam int IDX_W        = 13;
  localparam int DEF_CAPACITY = 128;
  // Cells per first-level read OR group.
  localparam int GRP          = 16;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    logic              ins;   // open a slot at 'at', shift higher cells up
    logic              del;   // close the slot at 'at', shift higher cells down
    logic [IDX_W-1:0]  at;    // target index (also the read index)
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

### src/indexed_array_list_top.sv
// Top level of the indexed array list: cell chain, control and read tree.
// Result path: cell update and group OR in stage 1, then the final OR in the output register.
// Throughput: one operation per cycle unless a result is stalled; every cell shifts in the
//   same cycle, so insert/erase cost the same as append/read.
// The input stalls only while a finished result waits on a stalled output.
// Reset (rst_n low, synchronous): count cleared, pipeline emptied; entry contents
//   are not cleared and need no clearing pass.
module indexed_array_list_top
  import iaal_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // operation channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [POS_W-1:0]     in_position,
  input  logic signed [31:0]   in_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_read_value,
  output logic [OUT_CNT_W-1:0] out_count,
  output logic                 out_is_empty,
  output logic [1:0]           out_status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;
  localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

  // ---------------------------------------------------------------
  // Handshake: whole pipe advances unless a result sits stalled.
  // ---------------------------------------------------------------
  logic advance;
  logic in_xfer;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign in_xfer  = in_valid && advance;

  // ---------------------------------------------------------------
  // Count and operation decode
  // ---------------------------------------------------------------
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] cnt_ext, pos_ext;
  logic             full;
  status_t          status;
  cell_ctl_t        ctl;
  op_t              kind;

  assign kind    = op_t'(in_kind);
  assign cnt_ext = IDX_W'(cnt_r);
  assign pos_ext = IDX_W'(in_position);
  assign full    = (cnt_ext >= CAP_IDX);

  always_comb begin
    case (kind)
      OP_APPEND: status = full ? ST_FULL : ST_DONE;
      OP_INSERT: begin
        if (full)                   status = ST_FULL;
        else if (pos_ext > cnt_ext) status = ST_RANGE;
        else                        status = ST_DONE;
      end
      OP_ERASE, OP_READ: status = (pos_ext >= cnt_ext) ? ST_RANGE : ST_DONE;
      default: status = ST_DONE;
    endcase
  end

  always_comb begin
    ctl.ins   = in_xfer && (status == ST_DONE) && ((kind == OP_APPEND) || (kind == OP_INSERT));
    ctl.del   = in_xfer && (status == ST_DONE) && (kind == OP_ERASE);
    ctl.at    = (kind == OP_APPEND) ? cnt_ext : pos_ext;  // append = insert at the end
    ctl.value = in_value;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (ctl.del) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Cell chain: slot i talks to slots i-1 and i+1 only.
  // ---------------------------------------------------------------
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] rd_pad    [NGRP*GRP];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    iaal_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .rd_data    (rd_pad[i])
    );
  end

  for (genvar i = CAPACITY; i < NGRP*GRP; i++) begin : g_pad
    assign rd_pad[i] = '0;
  end

  // ---------------------------------------------------------------
  // Stage 1: per-group OR of the addressed cell (pre-update values).
  // ---------------------------------------------------------------
  logic [DATA_W-1:0] grp_or [NGRP];
  logic [DATA_W-1:0] s1_grp_r [NGRP];
  logic              s1_valid_r;
  logic              s1_rd_r;
  logic [CNT_W-1:0]  s1_cnt_r;
  status_t           s1_status_r;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        grp_or[g] = grp_or[g] | rd_pad[g*GRP + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_grp_r    <= grp_or;
      s1_rd_r     <= (kind == OP_READ) && (status == ST_DONE);
      s1_cnt_r    <= cnt_nxt;
      s1_status_r <= status;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: final OR across groups into the output register.
  // ---------------------------------------------------------------
  logic [DATA_W-1:0]    tree_or;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_rd_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;
  logic                 out_empty_r;
  status_t              out_status_r;

  always_comb begin
    tree_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      tree_or = tree_or | s1_grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rd_r     <= s1_rd_r ? tree_or : '0;
      out_cnt_r    <= OUT_CNT_W'(s1_cnt_r);   // low bits of the count
      out_empty_r  <= (s1_cnt_r == '0);
      out_status_r <= s1_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_count      = out_cnt_r;
  assign out_is_empty   = out_empty_r;
  assign out_status     = out_status_r;

endmodule

### src/iaal_cell.sv
// One list slot: holds an entry and trades it with its neighbors.
module iaal_cell
  import iaal_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_data,   // entry of slot IDX-1
  input  logic [DATA_W-1:0] right_data,  // entry of slot IDX+1
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data      // entry if this slot is addressed, else zero
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              hit;
  logic              above;

  assign hit   = (ctl.at == MY_IDX);
  assign above = (MY_IDX > ctl.at);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (hit) data_nxt = ctl.value;
      else if (above) data_nxt = left_data;
    end else if (ctl.del) begin
      if (hit || above) data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = hit ? data_r : '0;

endmodule

### src/iaal_checker.sv
// Port-level checks for the indexed array list, bound to the top level.
module iaal_checker
  import iaal_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [31:0]   out_read_value,
  input logic [OUT_CNT_W-1:0] out_count,
  input logic                 out_is_empty,
  input logic [1:0]           out_status
);

  // Input only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result transfer holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_value)
      && $stable(out_count) && $stable(out_status)))
    else $error("stalled result changed");

  // Empty flag agrees with the count.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // Failed operations return a zero read value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DONE)) |-> (out_read_value == '0))
    else $error("nonzero read value on error");

endmodule

bind indexed_array_list_top iaal_checker u_iaal_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value),
  .out_count      (out_count),
  .out_is_empty   (out_is_empty),
  .out_status     (out_status)
);
